// ===== design/bdfx_pkg.sv =====
package bdfx_pkg;

    // Store geometry: bytes are spread over eight banks by their low address bits
    localparam int STORE_BYTES = 256;
    localparam int BANKS       = 8;
    localparam int BANK_DEPTH  = STORE_BYTES / BANKS;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int ROW_W       = ADDR_W - 3;
    localparam int CNT_W       = $clog2(STORE_BYTES + 1);
    localparam int POS_W       = $clog2(STORE_BYTES * 8 + 1);
    localparam int WIN_BYTES   = 5;
    localparam int FIELD_MAX   = 32;

    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_EXTRACT = 2'd1;
    localparam logic [1:0] ACT_CLEAR   = 2'd2;

    localparam logic [1:0] ST_VALID   = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    typedef logic [BANKS-1:0][7:0] bank_data_t;

    typedef struct packed {
        logic [2:0] base_bank;
        logic [2:0] bit_off;
        logic [5:0] width;
    } fetch_ctl_t;

    typedef struct packed {
        logic [31:0] raw;
        logic        missing;
    } field_t;

endpackage

// ===== design/bdfx_store.sv =====
module bdfx_store (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [bdfx_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [7:0]                   wr_data,
    input  logic                         rd_en,
    input  logic [bdfx_pkg::POS_W-1:0]   rd_pos,
    output bdfx_pkg::bank_data_t         rd_data
);
    import bdfx_pkg::*;

    logic [ROW_W-1:0] base_row;
    logic [2:0]       base_bank;
    logic [ROW_W-1:0] rd_row [BANKS];

    assign base_row  = rd_pos[ROW_W+5:6];
    assign base_bank = rd_pos[5:3];

    // Each bank reads its own row: banks below the start bank hold the next row
    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        logic [7:0] mem [BANK_DEPTH];

        assign rd_row[b] = base_row + ROW_W'(3'(b) < base_bank);

        always_ff @(posedge aclk) begin
            if (wr_en && wr_addr[2:0] == 3'(b)) begin
                mem[wr_addr[ADDR_W-1:3]] <= wr_data;
            end
            if (rd_en) begin
                rd_data[b] <= mem[rd_row[b]];
            end
        end
    end

endmodule

// ===== design/bdfx_align.sv =====
module bdfx_align (
    input  logic                    aclk,
    input  logic                    en,
    input  bdfx_pkg::bank_data_t    bank_data,
    input  bdfx_pkg::fetch_ctl_t    ctl,
    output bdfx_pkg::field_t        field_reg
);
    import bdfx_pkg::*;

    logic [WIN_BYTES*8-1:0] win;
    logic [WIN_BYTES*8-1:0] shifted;
    logic [5:0]             rshift;
    logic [31:0]            raw;
    logic [31:0]            ones;
    field_t                 field_next;

    always_comb begin
        // Rotate banks into a five-byte window, first byte on top
        for (int j = 0; j < WIN_BYTES; j++) begin
            win[WIN_BYTES*8-1-8*j -: 8] = bank_data[3'(ctl.base_bank + 3'(j))];
        end
        shifted = win << ctl.bit_off;
        rshift  = 6'(FIELD_MAX) - ctl.width;
        raw     = shifted[WIN_BYTES*8-1 -: 32] >> rshift;
        ones    = 32'hFFFF_FFFF >> rshift;
        field_next.raw     = raw;
        field_next.missing = (raw == ones);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            field_reg <= field_next;
        end
    end

endmodule

// ===== design/bufr_data_field_extractor_top.sv =====
// Field extractor for the data section of a coded weather message.
// Input stream: each word carries an action in s_axis_tuser. A load appends
// data_byte to the byte store (ignored once the store is full), a clear
// starts a new message, an extract reads field_width bits MSB first from
// the running bit position and yields one result word. Width 0 gives none.
// Result stream: m_axis_tuser holds the status (valid, missing, error);
// m_axis_tdata holds the significand (raw + reference, zero unless valid)
// and the decimal scale passed through. Reading past the loaded bytes or a
// width above 32 reports an error and leaves the position unchanged.
// Throughput: one word per cycle while the output is not stalled, loads and
// extracts mixed freely. The position and byte count update at acceptance;
// the store is eight byte banks read together, so any field, spanning at
// most five bytes, needs a single read.
// Pipeline: bank read registered at acceptance, then bit alignment, then the
// reference add into the output register.
// Reset: aresetn low empties the store and zeroes the bit position; store
// contents are not cleared and need no clearing pass.
// Stall: while m_axis_tready is low with a result held, the whole pipeline
// holds and s_axis_tready drops.
module bufr_data_field_extractor_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // data_byte[7:0], field_width[13:8], reference_value[45:14],
    // decimal_scale[53:46], zero [55:54]
    input  logic [55:0] s_axis_tdata,
    // action[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // significand[33:0], scale_out[41:34], zero [47:42]
    output logic [47:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]  m_axis_tuser
);
    import bdfx_pkg::*;

    // Input word fields
    logic [1:0]        action;
    logic [7:0]        data_byte;
    logic [5:0]        field_width;
    logic [31:0]       reference_value;
    logic [7:0]        decimal_scale;

    logic              adv;
    logic              accept;
    logic              is_extract;
    logic              fld_err;
    logic [POS_W:0]    end_pos;
    logic [POS_W:0]    limit;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  loaded_reg, loaded_next;
    logic              wr_en;

    bank_data_t        bank_data;

    // Stage 1: store read in flight
    logic              st1_valid_reg;
    logic              st1_err_reg;
    fetch_ctl_t        st1_ctl_reg;
    logic [31:0]       st1_ref_reg;
    logic [7:0]        st1_scale_reg;

    // Stage 2: aligned field
    logic              st2_valid_reg;
    logic              st2_err_reg;
    logic [31:0]       st2_ref_reg;
    logic [7:0]        st2_scale_reg;
    field_t            field_reg;

    // Output register
    logic              m_valid_reg;
    logic [1:0]        m_status_reg, m_status_next;
    logic [33:0]       m_sig_reg, m_sig_next;
    logic [7:0]        m_scale_reg;

    assign action          = s_axis_tuser;
    assign data_byte       = s_axis_tdata[7:0];
    assign field_width     = s_axis_tdata[13:8];
    assign reference_value = s_axis_tdata[45:14];
    assign decimal_scale   = s_axis_tdata[53:46];

    // Advance everything when the output register is free or being drained
    assign adv           = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;

    assign is_extract = (action == ACT_EXTRACT) && (field_width != 6'd0);
    assign end_pos    = (POS_W+1)'(pos_reg) + (POS_W+1)'(field_width);
    assign limit      = (POS_W+1)'({loaded_reg, 3'b000});
    assign fld_err    = (field_width > 6'(FIELD_MAX)) || (end_pos > limit);
    assign wr_en      = accept && (action == ACT_LOAD) && (loaded_reg != CNT_W'(STORE_BYTES));

    always_comb begin
        pos_next    = pos_reg;
        loaded_next = loaded_reg;
        if (accept) begin
            case (action)
                ACT_LOAD: begin
                    if (wr_en) begin
                        loaded_next = loaded_reg + CNT_W'(1);
                    end
                end
                ACT_EXTRACT: begin
                    // advance only on a field that fits
                    if (is_extract && !fld_err) begin
                        pos_next = end_pos[POS_W-1:0];
                    end
                end
                ACT_CLEAR: begin
                    pos_next    = '0;
                    loaded_next = '0;
                end
                default: begin
                    // unused action: drop
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            loaded_reg <= '0;
        end else begin
            pos_reg    <= pos_next;
            loaded_reg <= loaded_next;
        end
    end

    bdfx_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (loaded_reg[ADDR_W-1:0]),
        .wr_data (data_byte),
        .rd_en   (accept && is_extract),
        .rd_pos  (pos_reg),
        .rd_data (bank_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (adv) begin
            st1_valid_reg <= accept && is_extract;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && is_extract) begin
            st1_err_reg           <= fld_err;
            st1_ctl_reg.base_bank <= pos_reg[5:3];
            st1_ctl_reg.bit_off   <= pos_reg[2:0];
            st1_ctl_reg.width     <= field_width;
            st1_ref_reg           <= reference_value;
            st1_scale_reg         <= decimal_scale;
        end
    end

    bdfx_align u_align (
        .aclk      (aclk),
        .en        (adv && st1_valid_reg),
        .bank_data (bank_data),
        .ctl       (st1_ctl_reg),
        .field_reg (field_reg)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_valid_reg <= 1'b0;
        end else if (adv) begin
            st2_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && st1_valid_reg) begin
            st2_err_reg   <= st1_err_reg;
            st2_ref_reg   <= st1_ref_reg;
            st2_scale_reg <= st1_scale_reg;
        end
    end

    // Status and significand: the sum of a 32-bit unsigned and a signed
    // reference always fits in 34 signed bits
    always_comb begin
        if (st2_err_reg) begin
            m_status_next = ST_ERROR;
            m_sig_next    = '0;
        end else if (field_reg.missing) begin
            m_status_next = ST_MISSING;
            m_sig_next    = '0;
        end else begin
            m_status_next = ST_VALID;
            m_sig_next    = {2'b00, field_reg.raw} + {{2{st2_ref_reg[31]}}, st2_ref_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= st2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && st2_valid_reg) begin
            m_status_reg <= m_status_next;
            m_sig_reg    <= m_sig_next;
            m_scale_reg  <= st2_scale_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {6'd0, m_scale_reg, m_sig_reg};

    a_pos_in_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (POS_W+1)'(pos_reg) <= (POS_W+1)'({loaded_reg, 3'b000}))
        else $error("bit position beyond loaded bytes");

    a_loaded_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        loaded_reg <= CNT_W'(STORE_BYTES))
        else $error("byte count beyond store size");

    a_sig_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != ST_VALID) |-> (m_sig_reg == 34'd0))
        else $error("significand not zero on missing or error");

    a_st1_to_st2: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_valid_reg && adv) |=> st2_valid_reg)
        else $error("extract lost between read and align stages");

endmodule

// ===== verif/bufr_data_field_extractor_top_test.sv =====
`timescale 1ns / 1ps

module bufr_data_field_extractor_top_test;

    import bdfx_pkg::*;

    // Action code the block must ignore
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Stop sending new messages once this many words have gone in
    localparam int WORD_TARGET = 1550;
    // Words at the head of the random part sent with both sides busy
    localparam int QUIET_WORDS = 250;
    // Pause after the last result (pipeline is three stages deep)
    localparam int TAIL_CYCLES = 12;

    // Expected result word: status, significand, pass-through scale
    typedef struct packed {
        logic [1:0]  status;
        logic [33:0] significand;
        logic [7:0]  scale;
    } field_result_t;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // data_byte[7:0], field_width[13:8], reference_value[45:14],
    // decimal_scale[53:46], zero [55:54]
    logic [55:0] s_axis_tdata  = '0;
    // action[1:0]
    logic [1:0]  s_axis_tuser  = ACT_LOAD;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // significand[33:0], scale_out[41:34], zero [47:42]
    logic [47:0] m_axis_tdata;
    // status[1:0]
    logic [1:0]  m_axis_tuser;

    // Model of the message store, kept in step with accepted words
    logic [7:0]  msg_store [STORE_BYTES];
    int unsigned msg_len;
    int unsigned read_pos;

    field_result_t pending_results [$];

    // Both sides busy while set; random gaps and stalls otherwise
    bit no_idle = 1'b0;

    int words_sent;
    int loads_seen;
    int extracts_seen;
    int clears_seen;
    int valid_checked;
    int missing_checked;
    int error_checked;
    int mismatch_count;

    bufr_data_field_extractor_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Result side back-pressure: stall with a chance of about 28 in a hundred
    always @(posedge aclk) begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 28);
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // Advance the store model by one accepted word and queue any result it causes
    task automatic model_word(input logic [1:0] act, input logic [7:0] data_b,
                              input logic [5:0] width, input logic [31:0] refv,
                              input logic [7:0] scale);
        field_result_t want;
        logic [31:0]   raw;
        logic [31:0]   ones;
        int unsigned   p;
        case (act)
            ACT_LOAD: begin
                loads_seen++;
                // Drop the byte once the store is full
                if (msg_len < STORE_BYTES) begin
                    msg_store[msg_len] = data_b;
                    msg_len++;
                end
            end
            ACT_CLEAR: begin
                clears_seen++;
                msg_len  = 0;
                read_pos = 0;
            end
            ACT_EXTRACT: begin
                extracts_seen++;
                // A zero-width field is skipped without a result word
                if (width != 0) begin
                    want.scale = scale;
                    if (width > FIELD_MAX || read_pos + width > msg_len * 8) begin
                        // Bad width or read past the loaded bytes: position holds
                        want.status      = ST_ERROR;
                        want.significand = '0;
                    end else begin
                        raw = '0;
                        for (int i = 0; i < width; i++) begin
                            p   = read_pos + i;
                            raw = {raw[30:0], msg_store[p >> 3][7 - (p & 7)]};
                        end
                        read_pos += width;
                        ones = (width == FIELD_MAX) ? 32'hFFFF_FFFF
                                                    : 32'((64'd1 << width) - 1);
                        if (raw == ones) begin
                            want.status      = ST_MISSING;
                            want.significand = '0;
                        end else begin
                            // Raw is unsigned, reference sign-extended into 34 bits
                            want.status      = ST_VALID;
                            want.significand = {2'b00, raw} + {{2{refv[31]}}, refv};
                        end
                    end
                    pending_results = {pending_results, want};
                end
            end
            default: ;
        endcase
    endtask

    // Send one word with an optional random gap in front, hold until taken
    task automatic send_word(input logic [1:0] act, input logic [7:0] data_b,
                             input logic [5:0] width, input logic [31:0] refv,
                             input logic [7:0] scale);
        if (!no_idle) begin
            while ($urandom_range(99) < 28) begin
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {2'b00, scale, refv, width, data_b};
        // Sample the handshake mid-cycle, where nothing is changing
        do @(negedge aclk); while (!s_axis_tready);
        @(posedge aclk);
        words_sent++;
        model_word(act, data_b, width, refv, scale);
    endtask

    // References biased towards the extremes and the sign boundary
    function automatic logic [31:0] pick_reference();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Byte content with plenty of all-ones runs so missing fields turn up
    function automatic logic [7:0] pick_data_byte();
        return ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom);
    endfunction

    // Check each result word against the oldest expectation
    always @(negedge aclk) begin
        field_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result word with nothing expected, status %0d",
                                          m_axis_tuser));
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_axis_tuser, want.status));
                end
                if (m_axis_tdata[33:0] !== want.significand) begin
                    report_mismatch($sformatf("significand %h, expected %h",
                                              m_axis_tdata[33:0], want.significand));
                end
                if (m_axis_tdata[41:34] !== want.scale) begin
                    report_mismatch($sformatf("scale %h, expected %h",
                                              m_axis_tdata[41:34], want.scale));
                end
                case (want.status)
                    ST_VALID:   valid_checked++;
                    ST_MISSING: missing_checked++;
                    default:    error_checked++;
                endcase
            end
        end
    end

    // Hand-picked message: empty store, missing fields, extreme references
    // and scales, oversized widths, the last bit and one bit past the end
    task automatic test_directed_cases();
        logic [7:0] msg [10] = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                 8'h80, 8'h7F};
        send_word(ACT_EXTRACT, 8'h00, 6'd8, 32'd0, 8'd0);
        foreach (msg[i]) begin
            send_word(ACT_LOAD, msg[i], 6'd0, 32'd0, 8'd0);
        end
        send_word(ACT_EXTRACT, 8'h00, 6'd8, 32'd5, 8'd2);
        send_word(ACT_EXTRACT, 8'h00, 6'd0, 32'd0, 8'd0);
        send_word(ACT_EXTRACT, 8'h00, 6'd8, 32'h7FFF_FFFF, 8'h7F);
        send_word(ACT_EXTRACT, 8'h00, 6'd16, 32'h8000_0000, 8'h80);
        send_word(ACT_EXTRACT, 8'h00, 6'd33, 32'd1, 8'd1);
        send_word(ACT_EXTRACT, 8'hFF, 6'd63, 32'hFFFF_FFFF, 8'hFF);
        send_word(ACT_EXTRACT, 8'h00, 6'd32, 32'd0, 8'd0);
        send_word(ACT_EXTRACT, 8'h00, 6'd3, 32'hFFFF_FFFF, 8'd3);
        send_word(ACT_EXTRACT, 8'h00, 6'd12, 32'd100, 8'hFE);
        send_word(ACT_EXTRACT, 8'h00, 6'd1, 32'd0, 8'd0);
        send_word(ACT_EXTRACT, 8'h00, 6'd1, 32'd0, 8'd0);
        send_word(ACT_UNUSED, 8'hFF, 6'd8, 32'hFFFF_FFFF, 8'hFF);
    endtask

    // Fill the store past its end, then read it out to the last bit
    task automatic test_store_full();
        int unsigned pos;
        int unsigned w;
        send_word(ACT_CLEAR, 8'($urandom), 6'($urandom), $urandom, 8'($urandom));
        for (int i = 0; i < STORE_BYTES + 4; i++) begin
            // Lead with FF FF FF FE for the largest valid sum
            send_word(ACT_LOAD, (i < 3) ? 8'hFF : (i == 3) ? 8'hFE : pick_data_byte(),
                      6'($urandom), $urandom, 8'($urandom));
        end
        send_word(ACT_EXTRACT, 8'h00, 6'd32, 32'h7FFF_FFFF, 8'($urandom));
        pos = 32;
        while (pos < STORE_BYTES * 8) begin
            w = $urandom_range(1, FIELD_MAX);
            if (pos + w > STORE_BYTES * 8) begin
                w = STORE_BYTES * 8 - pos;
            end
            send_word(ACT_EXTRACT, 8'($urandom), 6'(w), pick_reference(), 8'($urandom));
            pos += w;
        end
        send_word(ACT_EXTRACT, 8'($urandom), 6'd1, pick_reference(), 8'($urandom));
    endtask

    // Random messages: clear, load, extract fields across the loaded bits,
    // with noise words and the odd read past the end mixed in
    task automatic test_random_messages();
        int quiet_end;
        int n_bytes;
        int bits_left;
        int w;
        quiet_end = words_sent + QUIET_WORDS;
        no_idle   = 1'b1;
        while (words_sent < WORD_TARGET) begin
            if (words_sent >= quiet_end) begin
                no_idle = 1'b0;
            end
            n_bytes = ($urandom_range(39) == 0) ? $urandom_range(200, STORE_BYTES)
                                                : $urandom_range(1, 16);
            send_word(ACT_CLEAR, 8'($urandom), 6'($urandom), $urandom, 8'($urandom));
            repeat (n_bytes) begin
                send_word(ACT_LOAD, pick_data_byte(), 6'($urandom), $urandom,
                          8'($urandom));
            end
            bits_left = n_bytes * 8;
            while (bits_left > 0) begin
                if ($urandom_range(99) < 12) begin
                    // Noise: any action, any width, including the unused code
                    send_word(2'($urandom), pick_data_byte(), 6'($urandom),
                              pick_reference(), 8'($urandom));
                end else begin
                    if (bits_left >= FIELD_MAX && $urandom_range(5) == 0) begin
                        w = FIELD_MAX;
                    end else begin
                        w = $urandom_range(1, (bits_left < FIELD_MAX) ? bits_left
                                                                      : FIELD_MAX);
                    end
                    send_word(ACT_EXTRACT, 8'($urandom), 6'(w), pick_reference(),
                              8'($urandom));
                    bits_left -= w;
                end
            end
            if ($urandom_range(1) == 0) begin
                send_word(ACT_EXTRACT, 8'($urandom), 6'($urandom_range(1, 63)),
                          pick_reference(), 8'($urandom));
            end
        end
    endtask

    initial begin
        msg_len  = 0;
        read_pos = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_store_full();
        test_random_messages();

        // Let the pipeline empty with the result side still stalling at random
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d words: %0d loads, %0d extracts, %0d clears",
                 words_sent, loads_seen, extracts_seen, clears_seen);
        $display("Checked results: %0d valid, %0d missing, %0d error; %0d mismatches",
                 valid_checked, missing_checked, error_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest correct run
    initial begin
        #4000000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
